// ----- hdl/acgr_pkg.sv -----
// acgr_pkg: shared constants, types and the window table of the grain resynthesizer
// used by acgr_ctrl, acgr_dp and autocorrelation_grain_resynth_unit
`default_nettype none

package acgr_pkg;

   localparam int RING_DEPTH = 256;
   localparam int RING_AW    = 8;
   localparam int LAG_COUNT  = 128;
   localparam int LAG_AW     = 7;
   localparam int WIN_LEN    = 2 * LAG_COUNT;
   localparam int SQ_STEPS   = 32;
   localparam int DIV_STEPS  = 22;
   localparam int GRAIN_TERMS = 2 * LAG_COUNT - 1;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   localparam logic [15:0] COEFF_RESET = 16'd65483;
   localparam logic [31:0] STEP_RESET  = 32'd0;

   localparam logic [0:0] REG_COEFF = 1'b0;
   localparam logic [0:0] REG_STEP  = 1'b1;

   typedef logic [16:0] win_tab_type [WIN_LEN];

   typedef struct packed {
      logic       clr;
      logic       accept;
      logic       lag_rd;
      logic       lag_mul1;
      logic       lag_mul2;
      logic       lag_wr;
      logic       sq_init;
      logic       sq_step;
      logic       dv_init;
      logic       dv_step;
      logic       gr_rd;
      logic       gr_mul1;
      logic       gr_mul2;
      logic       gr_wr;
      logic       out_rd;
      logic       out_mul;
      logic       out_load;
      logic [7:0] idx;
   } acgr_cmd_type;

   typedef struct packed {
      logic fire;
      logic rsp_busy;
   } acgr_status_type;

   function automatic win_tab_type build_win();
      win_tab_type tab;
      logic [63:0] j;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] t;
      logic [63:0] s;
      for (int i = 0; i < WIN_LEN; i++) begin
         j = (i <= WIN_LEN / 2) ? 64'(i) : 64'(WIN_LEN - i);
         a = (PI_Q30 * j + 64'(WIN_LEN / 2)) / WIN_LEN;
         a2 = (a * a) >> 30;
         t = ONE_Q30;
         t = ONE_Q30 - ((a2 * t) >> 30) / 110;
         t = ONE_Q30 - ((a2 * t) >> 30) / 72;
         t = ONE_Q30 - ((a2 * t) >> 30) / 42;
         t = ONE_Q30 - ((a2 * t) >> 30) / 20;
         t = ONE_Q30 - ((a2 * t) >> 30) / 6;
         s = (a * t) >> 30;
         tab[i] = 17'((s * s + (64'd1 << 43)) >> 44);
      end
      return tab;
   endfunction

   localparam win_tab_type WIN_TAB = build_win();

   function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
      logic signed [31:0] r;
      if (v > 42'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -42'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      logic signed [15:0] r;
      if (v > 19'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -19'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/autocorrelation_grain_resynth_unit.sv -----
// autocorrelation_grain_resynth_unit: top level of the grain resynthesizer
// holds the csr registers, instantiates acgr_ctrl and acgr_dp; uses acgr_pkg
//
// usage:
//   req channel carries one audio sample and its envelope gain per request;
//   rsp channel returns exactly one output sample per request, in order.
//   csr port (apb style, pready always high) holds smoothing_coeff at 0x0
//   and phase_step at 0x4; write them only while the block is idle.
// sequence:
//   after reset a clearing pass zeroes all memories; req_tready
//   stays low until it ends. each request then runs the 128 lag updates,
//   each a read, two multiply steps and a write; when a grain fires it
//   adds a 32-step square root, a 22-step divide and the 255 grain terms,
//   each a read, two multiply steps and an overlap memory write. one
//   request is in work at a time. the result sits in an output register; if
//   rsp_tready is low the next request is still accepted and processed, and
//   only its final output step waits until the previous result has been
//   taken.
`default_nettype none

module autocorrelation_grain_resynth_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,    // sample_in [15:0], env_gain [31:16]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,    // sample_out [15:0]
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0] coeff_ff;
   logic [31:0] step_ff;
   logic        csr_wr;

   acgr_pkg::acgr_cmd_type    cmd;
   acgr_pkg::acgr_status_type status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= acgr_pkg::COEFF_RESET;
         step_ff  <= acgr_pkg::STEP_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            acgr_pkg::REG_COEFF: coeff_ff <= csr_pwdata[15:0];
            acgr_pkg::REG_STEP:  step_ff  <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         acgr_pkg::REG_COEFF: csr_prdata = {16'd0, coeff_ff};
         acgr_pkg::REG_STEP:  csr_prdata = step_ff;
         default:             csr_prdata = '0;
      endcase
   end

   acgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   acgr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .coeff      (coeff_ff),
      .phase_step (step_ff),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- hdl/acgr_ctrl.sv -----
// acgr_ctrl: sequencer of the grain resynthesizer
// steps acgr_dp through clear, lag update, reciprocal root, grain add and output; uses acgr_pkg
`default_nettype none

module acgr_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  acgr_pkg::acgr_status_type status,
   output acgr_pkg::acgr_cmd_type    cmd
);

   localparam logic [4:0] S_CLR  = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_LRD  = 5'd2;
   localparam logic [4:0] S_LM1  = 5'd3;
   localparam logic [4:0] S_LM2  = 5'd4;
   localparam logic [4:0] S_LWR  = 5'd5;
   localparam logic [4:0] S_SQI  = 5'd6;
   localparam logic [4:0] S_SQ   = 5'd7;
   localparam logic [4:0] S_DVI  = 5'd8;
   localparam logic [4:0] S_DV   = 5'd9;
   localparam logic [4:0] S_GRD  = 5'd10;
   localparam logic [4:0] S_GM1  = 5'd11;
   localparam logic [4:0] S_GM2  = 5'd12;
   localparam logic [4:0] S_GWR  = 5'd13;
   localparam logic [4:0] S_ORD  = 5'd14;
   localparam logic [4:0] S_OMUL = 5'd15;
   localparam logic [4:0] S_OOUT = 5'd16;

   logic [4:0] state_ff, state_in;
   logic [7:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      cmd.idx   = idx_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_CLR: begin
            cmd.clr = 1'b1;
            idx_in  = idx_ff + 8'd1;
            if (idx_ff == 8'(acgr_pkg::RING_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            idx_in    = '0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LRD;
            end
         end
         S_LRD: begin
            cmd.lag_rd = 1'b1;
            state_in   = S_LM1;
         end
         S_LM1: begin
            cmd.lag_mul1 = 1'b1;
            state_in     = S_LM2;
         end
         S_LM2: begin
            cmd.lag_mul2 = 1'b1;
            state_in     = S_LWR;
         end
         S_LWR: begin
            cmd.lag_wr = 1'b1;
            idx_in     = idx_ff + 8'd1;
            state_in   = S_LRD;
            if (idx_ff == 8'(acgr_pkg::LAG_COUNT - 1)) begin
               idx_in   = '0;
               state_in = status.fire ? S_SQI : S_ORD;
            end
         end
         S_SQI: begin
            cmd.sq_init = 1'b1;
            state_in    = S_SQ;
         end
         S_SQ: begin
            cmd.sq_step = 1'b1;
            idx_in      = idx_ff + 8'd1;
            if (idx_ff == 8'(acgr_pkg::SQ_STEPS - 1)) begin
               idx_in   = '0;
               state_in = S_DVI;
            end
         end
         S_DVI: begin
            cmd.dv_init = 1'b1;
            state_in    = S_DV;
         end
         S_DV: begin
            cmd.dv_step = 1'b1;
            idx_in      = idx_ff + 8'd1;
            if (idx_ff == 8'(acgr_pkg::DIV_STEPS - 1)) begin
               idx_in   = '0;
               state_in = S_GRD;
            end
         end
         S_GRD: begin
            cmd.gr_rd = 1'b1;
            state_in  = S_GM1;
         end
         S_GM1: begin
            cmd.gr_mul1 = 1'b1;
            state_in    = S_GM2;
         end
         S_GM2: begin
            cmd.gr_mul2 = 1'b1;
            state_in    = S_GWR;
         end
         S_GWR: begin
            cmd.gr_wr = 1'b1;
            idx_in    = idx_ff + 8'd1;
            state_in  = S_GRD;
            if (idx_ff == 8'(acgr_pkg::GRAIN_TERMS - 1)) begin
               idx_in   = '0;
               state_in = S_ORD;
            end
         end
         S_ORD: begin
            cmd.out_rd = 1'b1;
            state_in   = S_OMUL;
         end
         S_OMUL: begin
            cmd.out_mul = 1'b1;
            state_in    = S_OOUT;
         end
         S_OOUT: begin
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/acgr_dp.sv -----
// acgr_dp: datapath of the grain resynthesizer
// history, lag and overlap memories, multipliers, root and divide units; uses acgr_pkg
`default_nettype none

module acgr_dp (
   input  wire                        clock,
   input  wire                        reset,
   input  acgr_pkg::acgr_cmd_type     cmd,
   output acgr_pkg::acgr_status_type  status,
   input  wire  [15:0]                coeff,
   input  wire  [31:0]                phase_step,
   input  wire  [31:0]                req_tdata,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [15:0]                rsp_tdata
);

   logic signed [15:0] hist_mem [acgr_pkg::RING_DEPTH];
   logic signed [31:0] lag_mem  [acgr_pkg::LAG_COUNT];
   logic signed [31:0] ring_mem [acgr_pkg::RING_DEPTH];

   logic [7:0]         pos_ff;
   logic [31:0]        phase_ff;
   logic               fire_ff;
   logic signed [15:0] x_ff;
   logic [15:0]        env_ff;
   logic signed [15:0] hist_q_ff;
   logic signed [31:0] lag_q_ff;
   logic signed [31:0] ring_q_ff;
   logic signed [31:0] lag0_ff;
   logic signed [31:0] prod_ff;
   logic signed [48:0] m1_ff;
   logic signed [49:0] m2_ff;
   logic [16:0]        w_ff;
   logic signed [33:0] t_ff;
   logic signed [40:0] term_ff;
   logic signed [48:0] op_ff;
   logic [63:0]        n_ff, r_ff, b_ff;
   logic [32:0]        rem_ff;
   logic [21:0]        q_ff;
   logic               rsp_valid_ff;
   logic [15:0]        rsp_data_ff;

   logic [31:0]        phase_sum;
   logic [16:0]        kc;
   logic signed [50:0] lag_sum;
   logic signed [31:0] lag_new;
   logic signed [49:0] g1;
   logic signed [56:0] g2;
   logic signed [31:0] ring_new;
   logic signed [49:0] y_sum;
   logic [31:0]        v;
   logic [63:0]        rb;
   logic [32:0]        rem2;
   logic [7:0]         gr_lag;
   logic [7:0]         hist_ra;
   logic [6:0]         lag_ra;
   logic [7:0]         ring_ra;
   logic [7:0]         ring_wa;
   logic signed [31:0] ring_wd;
   logic               ring_we;

   always_comb begin
      phase_sum = phase_ff + phase_step;
      kc        = 17'h10000 - {1'b0, coeff};
      lag_sum   = 51'(m1_ff) + 51'(m2_ff) + 51'sd32768;
      lag_new   = acgr_pkg::sat32(42'(35'(lag_sum >>> 16)));
      g1        = lag_q_ff * $signed({1'b0, w_ff});
      g2        = t_ff * $signed({1'b0, q_ff});
      ring_new  = acgr_pkg::sat32(42'(ring_q_ff) + 42'(term_ff));
      y_sum     = 50'(op_ff) + 50'sd1073741824;
      v         = (lag0_ff[31] ? 32'd0 : 32'(lag0_ff)) + 32'd1048576;
      rb        = r_ff + b_ff;
      rem2      = {rem_ff[31:0], 1'b0};
      gr_lag    = (cmd.idx < 8'(acgr_pkg::LAG_COUNT - 1)) ?
                  8'(acgr_pkg::LAG_COUNT - 1) - cmd.idx :
                  cmd.idx - 8'(acgr_pkg::LAG_COUNT - 1);
      hist_ra   = pos_ff - {1'b0, cmd.idx[acgr_pkg::LAG_AW-1:0]};
      lag_ra    = cmd.gr_rd ? gr_lag[acgr_pkg::LAG_AW-1:0] : cmd.idx[acgr_pkg::LAG_AW-1:0];
      ring_ra   = cmd.gr_rd ? pos_ff + cmd.idx : pos_ff;
      ring_we   = cmd.clr | cmd.gr_wr | cmd.out_mul;
      ring_wa   = cmd.clr ? cmd.idx : (cmd.gr_wr ? pos_ff + cmd.idx : pos_ff);
      ring_wd   = cmd.gr_wr ? ring_new : 32'sd0;
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         hist_mem[cmd.idx] <= '0;
      end else if (cmd.accept) begin
         hist_mem[pos_ff] <= $signed(req_tdata[15:0]);
      end
      if (cmd.lag_rd) begin
         hist_q_ff <= hist_mem[hist_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         lag_mem[cmd.idx[acgr_pkg::LAG_AW-1:0]] <= '0;
      end else if (cmd.lag_wr) begin
         lag_mem[cmd.idx[acgr_pkg::LAG_AW-1:0]] <= lag_new;
      end
      if (cmd.lag_rd || cmd.gr_rd) begin
         lag_q_ff <= lag_mem[lag_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_wa] <= ring_wd;
      end
      if (cmd.gr_rd || cmd.out_rd) begin
         ring_q_ff <= ring_mem[ring_ra];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= '0;
         fire_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            phase_ff <= phase_sum;
            fire_ff  <= phase_sum < phase_step;
         end
         if (cmd.out_load) begin
            pos_ff       <= pos_ff + 8'd1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // arithmetic pipeline
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff   <= $signed(req_tdata[15:0]);
         env_ff <= req_tdata[31:16];
      end
      if (cmd.clr) begin
         lag0_ff <= '0;
      end else if (cmd.lag_wr && cmd.idx == 8'd0) begin
         lag0_ff <= lag_new;
      end
      if (cmd.lag_mul1) begin
         prod_ff <= x_ff * hist_q_ff;
         m1_ff   <= lag_q_ff * $signed({1'b0, coeff});
      end
      if (cmd.lag_mul2) begin
         m2_ff <= prod_ff * $signed({1'b0, kc});
      end
      if (cmd.gr_rd) begin
         w_ff <= acgr_pkg::WIN_TAB[cmd.idx + 8'd1];
      end
      if (cmd.gr_mul1) begin
         t_ff <= 34'((g1 + 50'sd32768) >>> 16);
      end
      if (cmd.gr_mul2) begin
         term_ff <= 41'((g2 + 57'sd32768) >>> 16);
      end
      if (cmd.out_mul) begin
         op_ff <= ring_q_ff * $signed({1'b0, env_ff});
      end
      if (cmd.out_load) begin
         rsp_data_ff <= acgr_pkg::sat16(19'(y_sum >>> 31));
      end
   end

   // integer square root, two bits per step, then 2^46 / root
   always_ff @(posedge clock) begin
      if (cmd.sq_init) begin
         n_ff <= {2'b00, v, 30'd0};
         r_ff <= '0;
         b_ff <= 64'd1 << 62;
      end else if (cmd.sq_step) begin
         if (n_ff >= rb) begin
            n_ff <= n_ff - rb;
            r_ff <= (r_ff >> 1) + b_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         b_ff <= b_ff >> 2;
      end
      if (cmd.dv_init) begin
         rem_ff <= 33'd1 << 24;
         q_ff   <= '0;
      end else if (cmd.dv_step) begin
         if (rem2 >= {1'b0, r_ff[31:0]}) begin
            rem_ff <= rem2 - {1'b0, r_ff[31:0]};
            q_ff   <= {q_ff[20:0], 1'b1};
         end else begin
            rem_ff <= rem2;
            q_ff   <= {q_ff[20:0], 1'b0};
         end
      end
   end

   assign status.fire     = fire_ff;
   assign status.rsp_busy = rsp_valid_ff & ~rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

`default_nettype wire

// ----- test/tb_autocorrelation_grain_resynth_unit.sv -----
// tb_autocorrelation_grain_resynth_unit: self-checking bench for the grain resynthesizer,
// predicts every output sample from its own lag, phase and overlap model and compares
// them in order; depends on acgr_pkg and autocorrelation_grain_resynth_unit
`timescale 1ns / 1ps

module tb_autocorrelation_grain_resynth_unit;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [31:0] req_tdata = '0;    // sample_in [15:0], env_gain [31:16]
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [15:0] rsp_tdata;         // sample_out [15:0]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   autocorrelation_grain_resynth_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // model state
   logic signed [15:0] hist_ring [acgr_pkg::RING_DEPTH];
   longint             lag_acc [acgr_pkg::LAG_COUNT];
   longint             grain_ring [acgr_pkg::RING_DEPTH];
   longint unsigned    hann_tab [acgr_pkg::WIN_LEN];
   logic [7:0]         write_pos;
   logic [31:0]        phase_acc;
   logic [15:0]        coeff_k;
   logic [31:0]        phase_step;

   logic [31:0] pending_requests [$];
   logic [15:0] expected_samples [$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          errors = 0;
   int          samples_checked = 0;
   int          grains_fired = 0;

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic longint clip32(input longint v);
      longint r;
      r = v;
      if (v > 64'sd2147483647) r = 64'sd2147483647;
      if (v < -64'sd2147483648) r = -64'sd2147483648;
      return r;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void make_hann();
      longint unsigned j, a, a2, t, s;
      longint unsigned divs [5];
      divs = '{110, 72, 42, 20, 6};
      for (int i = 0; i < acgr_pkg::WIN_LEN; i++) begin
         j = (i <= acgr_pkg::WIN_LEN / 2) ? i : acgr_pkg::WIN_LEN - i;
         a = (64'd3373259426 * j + acgr_pkg::WIN_LEN / 2) / acgr_pkg::WIN_LEN;
         a2 = (a * a) >> 30;
         t = 64'd1 << 30;
         for (int d = 0; d < 5; d++) t = (64'd1 << 30) - ((a2 * t) >> 30) / divs[d];
         s = (a * t) >> 30;
         hann_tab[i] = (s * s + (64'd1 << 43)) >> 44;
      end
   endfunction

   function automatic longint grain_term(input longint lag, input longint unsigned w,
                                         input longint scale);
      longint t;
      t = (lag * longint'(w) + 32768) >>> 16;
      return (t * scale + 32768) >>> 16;
   endfunction

   function automatic void add_grain(input logic [7:0] idx, input longint v);
      grain_ring[idx] = clip32(grain_ring[idx] + v);
   endfunction

   function automatic logic [15:0] predict_sample(input logic [31:0] request);
      logic signed [15:0] x;
      longint             env, k, prod, y, scale;
      logic [7:0]         rd;
      longint unsigned    v;
      x = request[15:0];
      env = longint'(request[31:16]);
      k = longint'(coeff_k);
      hist_ring[write_pos] = x;
      for (int l = 0; l < acgr_pkg::LAG_COUNT; l++) begin
         rd = write_pos - 8'(l);
         prod = longint'(x) * longint'(hist_ring[rd]);
         lag_acc[l] = clip32((lag_acc[l] * k + prod * (65536 - k) + 32768) >>> 16);
      end
      phase_acc = phase_acc + phase_step;
      if (phase_acc < phase_step) begin
         grains_fired++;
         v = longint'(lag_acc[0] < 0 ? 0 : lag_acc[0]) + (64'd1 << 20);
         scale = longint'((64'd1 << 46) / int_sqrt(v << 30));
         for (int m = 1; m < acgr_pkg::LAG_COUNT; m++)
            add_grain(write_pos + 8'(m - 1),
                      grain_term(lag_acc[acgr_pkg::LAG_COUNT - m], hann_tab[m], scale));
         for (int m = 0; m < acgr_pkg::LAG_COUNT; m++)
            add_grain(write_pos + 8'(acgr_pkg::LAG_COUNT - 1 + m),
                      grain_term(lag_acc[m], hann_tab[m + acgr_pkg::LAG_COUNT], scale));
      end
      y = (grain_ring[write_pos] * env + (64'sd1 << 30)) >>> 31;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      grain_ring[write_pos] = 0;
      write_pos = write_pos + 8'd1;
      return y[15:0];
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_requests.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   logic [15:0] want;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) expected_samples.push_back(predict_sample(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            samples_checked++;
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("unexpected sample_out %h", rsp_tdata));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata !== want)
                  report_mismatch($sformatf("sample_out %h, want %h", rsp_tdata, want));
            end
         end
      end
   end

   task automatic csr_write(input logic [0:0] reg_sel, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (reg_sel == acgr_pkg::REG_COEFF) coeff_k = value[15:0];
      else phase_step = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_requests.size() > 0 || req_tvalid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] k, input logic [31:0] step, input int count,
                            input int send_pct, input int recv_pct);
      wait_idle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      csr_write(acgr_pkg::REG_COEFF, {16'd0, k});
      csr_write(acgr_pkg::REG_STEP, step);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0)
            pending_requests.push_back({$urandom_range(3) == 0 ? 16'hffff : 16'($urandom),
                                        $urandom_range(1) ? 16'h7fff : 16'h8000});
         else
            pending_requests.push_back($urandom);
      end
   endtask

   initial begin
      logic [15:0] edge_samples [6];
      logic [15:0] edge_gains [4];
      int send_mode [4];
      int recv_mode [4];
      edge_samples = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h5555};
      edge_gains = '{16'h0000, 16'hffff, 16'h0001, 16'h8000};
      send_mode = '{0, 61, 0, 29};
      recv_mode = '{0, 0, 61, 29};
      make_hann();
      for (int i = 0; i < acgr_pkg::RING_DEPTH; i++) begin
         hist_ring[i] = '0;
         grain_ring[i] = 0;
      end
      for (int i = 0; i < acgr_pkg::LAG_COUNT; i++) lag_acc[i] = 0;
      write_pos = '0;
      phase_acc = '0;
      coeff_k = acgr_pkg::COEFF_RESET;
      phase_step = acgr_pkg::STEP_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset coefficient, a grain every fourth request, field extremes
      csr_write(acgr_pkg::REG_STEP, 32'h4000_0000);
      for (int i = 0; i < 24; i++)
         pending_requests.push_back({edge_gains[i % 4], edge_samples[i % 6]});
      run_phase(16'd0, 32'h4000_0000, 8, 0, 0);
      run_phase(16'hffff, 32'hffff_ffff, 30, 0, 0);
      run_phase(16'hffff, 32'd0, 40, 0, 0);
      for (int p = 0; p < 8; p++)
         run_phase(16'($urandom), $urandom >> $urandom_range(1, 4), 113,
                   send_mode[p % 4], recv_mode[p % 4]);
      wait_idle();
      repeat (1700) @(posedge clock);
      $display("checked %0d output samples, %0d grains, coefficient and phase step swept",
               samples_checked, grains_fired);
      if (errors == 0) begin
         $display("tb_autocorrelation_grain_resynth_unit OK");
      end else begin
         $display("tb_autocorrelation_grain_resynth_unit NOT OK");
      end
      $finish;
   end

   initial begin
      #(12.0 * 8_000_000);
      $display("timeout");
      $display("tb_autocorrelation_grain_resynth_unit NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/acgr_pkg.sv
hdl/acgr_ctrl.sv
hdl/acgr_dp.sv
hdl/autocorrelation_grain_resynth_unit.sv
test/tb_autocorrelation_grain_resynth_unit.sv
